// ===== rtl/ptts_pkg.sv =====
// Shared types, codes and widths for the periodic task tick scheduler.
package ptts_pkg;

    // Field widths
    localparam int FUNC_W        = 3;
    localparam int SLOT_W        = 8;
    localparam int WORD_W        = 32;
    localparam int KIND_W        = 2;
    localparam int STAT_W        = 2;
    localparam int TASK_W        = 3;
    localparam int IN_TDATA_W    = 80;
    localparam int OUT_TDATA_W   = 8;
    localparam int DEF_NUM_SLOTS = 8;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_CREATE  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESUME  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SUSPEND = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd4;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERWRITE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BADSLOT   = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMD,
        ST_TICK,
        ST_DONE
    } t_state;

    // Write controls into the slot table
    typedef struct packed {
        logic              per_we;
        logic              cnt_we;
        logic              vld_set;
        logic [WORD_W-1:0] per_wdata;
        logic [WORD_W-1:0] cnt_wdata;
    } t_tbl_wr;

    // Result of one countdown step
    typedef struct packed {
        logic              active;
        logic              fire;
        logic [WORD_W-1:0] cnt_next;
    } t_step_res;

endpackage

// ===== rtl/periodic_task_tick_scheduler_core.sv =====
// Top level of the periodic task tick scheduler: sequencer and result register.
// A command (create, delete, resume, suspend) has an accept cycle, which also reads
// the addressed slot from the table, followed by an execute step that writes the
// table and posts the status once the output register is free. A tick has the
// accept cycle, one step per slot through the single shared decrement-and-compare
// unit, and a closing result posted once the output is free; a fire result meeting
// a full output register stalls that slot's step. The slot table comes out of
// reset empty through per-slot valid bits, with no clearing pass. The next item is
// taken once the previous one has handed its last result to the output register.
module periodic_task_tick_scheduler_core #(
    parameter int NUM_SLOTS = ptts_pkg::DEF_NUM_SLOTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] slot, [39:8] period, [71:40] first_delay, [72] initial_ready, rest zero
    input  logic [ptts_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [2:0] func
    input  logic [ptts_pkg::FUNC_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [1:0] status, [4:2] task_slot, [7:5] zero
    output logic [ptts_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [1:0] kind
    output logic [ptts_pkg::KIND_W-1:0]       m_axis_tuser,
    output logic                              m_axis_tlast
);
    import ptts_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    t_state r_state, n_state;

    logic [FUNC_W-1:0] r_func, n_func;
    logic              r_bad, n_bad;
    logic [WORD_W-1:0] r_period, n_period;
    logic [WORD_W-1:0] r_delay, n_delay;
    logic              r_irdy, n_irdy;
    logic [IW-1:0]     r_idx, n_idx;
    logic [NUM_SLOTS-1:0] r_rdy, n_rdy;

    logic              r_ovld;
    logic [KIND_W-1:0] r_okind;
    logic [STAT_W-1:0] r_ostat;
    logic [TASK_W-1:0] r_otask;
    logic              r_olast;

    logic              load_out;
    logic [KIND_W-1:0] out_kind;
    logic [STAT_W-1:0] out_stat;
    logic [TASK_W-1:0] out_task;
    logic              out_last;
    logic              out_free;
    logic              in_range;
    logic              idx_last;
    logic              stall;

    logic [IW-1:0]     rd_addr;
    t_tbl_wr           tbl_wr;
    logic [WORD_W-1:0] tbl_per;
    logic [WORD_W-1:0] tbl_cnt;
    t_step_res         step;

    ptts_slot_mem #(
        .NUM_SLOTS (NUM_SLOTS),
        .IW        (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_addr (r_idx),
        .i_wr      (tbl_wr),
        .i_rd_addr (rd_addr),
        .o_per     (tbl_per),
        .o_cnt     (tbl_cnt)
    );

    ptts_step_unit u_step (
        .i_per (tbl_per),
        .i_cnt (tbl_cnt),
        .i_rdy (r_rdy[r_idx]),
        .o_res (step)
    );

    assign out_free      = !r_ovld || m_axis_tready;
    assign in_range      = s_axis_tdata[SLOT_W-1:0] < SLOT_W'(NUM_SLOTS);
    assign idx_last      = (r_idx == IW'(NUM_SLOTS - 1));
    assign s_axis_tready = (r_state == ST_IDLE);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_rdy   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_rdy   <= n_rdy;
        end
    end

    // Latched command payload
    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_bad    <= n_bad;
        r_period <= n_period;
        r_delay  <= n_delay;
        r_irdy   <= n_irdy;
    end

    // Sequencer: next state, table writes and result selection
    always_comb begin
        n_state  = r_state;
        n_func   = r_func;
        n_bad    = r_bad;
        n_period = r_period;
        n_delay  = r_delay;
        n_irdy   = r_irdy;
        n_idx    = r_idx;
        n_rdy    = r_rdy;
        rd_addr  = r_idx;
        tbl_wr   = '0;
        load_out = 1'b0;
        out_kind = KIND_STATUS;
        out_stat = STAT_OK;
        out_task = '0;
        out_last = 1'b1;
        stall    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                // Read the addressed slot, or slot zero for a tick or an out-of-range slot
                rd_addr = (s_axis_tuser != FUNC_TICK && in_range)
                        ? IW'(s_axis_tdata[SLOT_W-1:0]) : '0;
                if (s_axis_tvalid) begin
                    n_func   = s_axis_tuser;
                    n_bad    = !in_range;
                    n_period = s_axis_tdata[SLOT_W +: WORD_W];
                    n_delay  = s_axis_tdata[SLOT_W + WORD_W +: WORD_W];
                    n_irdy   = s_axis_tdata[SLOT_W + 2*WORD_W];
                    n_idx    = rd_addr;
                    n_state  = (s_axis_tuser == FUNC_TICK) ? ST_TICK : ST_CMD;
                end
            end

            ST_CMD: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                    if (r_bad && r_func <= FUNC_SUSPEND) begin
                        out_stat = STAT_BADSLOT;
                    end else begin
                        unique case (r_func)
                            FUNC_CREATE: begin
                                if (tbl_per != '0) begin
                                    out_stat = STAT_OVERWRITE;
                                end else begin
                                    tbl_wr.per_we     = 1'b1;
                                    tbl_wr.cnt_we     = 1'b1;
                                    tbl_wr.vld_set    = 1'b1;
                                    tbl_wr.per_wdata  = r_period;
                                    tbl_wr.cnt_wdata  = r_delay;
                                    n_rdy[r_idx]      = r_irdy;
                                end
                            end
                            FUNC_DELETE: begin
                                tbl_wr.per_we = 1'b1;
                            end
                            FUNC_RESUME: begin
                                n_rdy[r_idx] = 1'b1;
                            end
                            FUNC_SUSPEND: begin
                                n_rdy[r_idx] = 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end

            ST_TICK: begin
                // Hold this slot while a fire result cannot be posted
                stall = step.fire && !out_free;
                if (!stall) begin
                    tbl_wr.cnt_we    = step.active;
                    tbl_wr.cnt_wdata = step.cnt_next;
                    if (step.fire) begin
                        load_out = 1'b1;
                        out_kind = KIND_FIRE;
                        out_task = TASK_W'(r_idx);
                        out_last = 1'b0;
                    end
                    if (idx_last) begin
                        n_state = ST_DONE;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        rd_addr = r_idx + IW'(1);
                    end
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    out_kind = KIND_DONE;
                    n_idx    = '0;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (load_out) begin
            r_ovld <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_okind <= out_kind;
            r_ostat <= out_stat;
            r_otask <= out_task;
            r_olast <= out_last;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {3'b000, r_otask, r_ostat};
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

    // An accepted item always starts work
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_state != ST_IDLE)
        else $error("accepted transaction did not start work");

    // A stalled slot keeps its index
    a_stall_holds_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_TICK && stall |=> r_state == ST_TICK && $stable(r_idx))
        else $error("tick slot moved during a stall");

    // Fire results never close a tick; closing and status results always do
    a_last_by_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_FIRE)))
        else $error("tlast does not match result kind");

    // A result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> !r_ovld || m_axis_tready)
        else $error("result register overwritten");

endmodule

// ===== rtl/ptts_slot_mem.sv =====
// Slot table: period and countdown memories with per-entry valid bits.
module ptts_slot_mem #(
    parameter int NUM_SLOTS = ptts_pkg::DEF_NUM_SLOTS,
    parameter int IW        = 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [IW-1:0]             i_wr_addr,
    input  ptts_pkg::t_tbl_wr         i_wr,
    input  logic [IW-1:0]             i_rd_addr,
    output logic [ptts_pkg::WORD_W-1:0] o_per,
    output logic [ptts_pkg::WORD_W-1:0] o_cnt
);
    import ptts_pkg::*;

    logic [WORD_W-1:0]    r_per_mem [NUM_SLOTS];
    logic [WORD_W-1:0]    r_cnt_mem [NUM_SLOTS];
    logic [WORD_W-1:0]    r_per_q;
    logic [WORD_W-1:0]    r_cnt_q;
    logic [IW-1:0]        r_rd_addr;
    logic [NUM_SLOTS-1:0] r_vld;

    // Write ports and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.per_we) begin
            r_per_mem[i_wr_addr] <= i_wr.per_wdata;
        end
        if (i_wr.cnt_we) begin
            r_cnt_mem[i_wr_addr] <= i_wr.cnt_wdata;
        end
        r_per_q   <= r_per_mem[i_rd_addr];
        r_cnt_q   <= r_cnt_mem[i_rd_addr];
        r_rd_addr <= i_rd_addr;
    end

    // Mark entries written by a create; reset leaves every slot empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.vld_set) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Entries never created read as zero
    assign o_per = r_vld[r_rd_addr] ? r_per_q : '0;
    assign o_cnt = r_vld[r_rd_addr] ? r_cnt_q : '0;

endmodule

// ===== rtl/ptts_step_unit.sv =====
// Shared countdown unit: decrement, zero compare and reload for one slot.
module ptts_step_unit (
    input  logic [ptts_pkg::WORD_W-1:0] i_per,
    input  logic [ptts_pkg::WORD_W-1:0] i_cnt,
    input  logic                        i_rdy,
    output ptts_pkg::t_step_res         o_res
);
    import ptts_pkg::*;

    logic [WORD_W-1:0] dec;

    // Saturate at zero so a countdown already at zero fires instead of wrapping
    always_comb begin
        dec            = (i_cnt != '0) ? (i_cnt - WORD_W'(1)) : '0;
        o_res.active   = (i_per != '0) && i_rdy;
        o_res.fire     = o_res.active && (dec == '0);
        o_res.cnt_next = o_res.fire ? i_per : dec;
    end

endmodule

// ===== verif/periodic_task_tick_scheduler_core_test.sv =====
// Self-checking testbench for the periodic task tick scheduler core.
module periodic_task_tick_scheduler_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ptts_pkg::*;

    localparam int          SLOTS           = DEF_NUM_SLOTS;
    localparam int          CLK_HALF        = 4;
    localparam int          RESET_CYCLES    = 5;
    localparam int          LIMIT_CYCLES    = 300000;
    localparam int          SETTLE_CYCLES   = 2 * (SLOTS + 2);
    localparam int          SEGMENTS        = 8;
    localparam int          SEGMENT_ITEMS   = 24;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_MID   = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;

    // One command as it enters the block
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] period;
        logic [WORD_W-1:0] first_delay;
        logic              initial_ready;
    } t_sched_cmd;

    // One result as it leaves the block
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [STAT_W-1:0] status;
        logic [TASK_W-1:0] task_slot;
        logic              last;
    } t_sched_result;

    // Slot table predictor and queue of expected results
    class sched_scoreboard;
        logic [WORD_W-1:0] period_tbl[SLOTS];
        logic [WORD_W-1:0] countdown_tbl[SLOTS];
        bit                ready_tbl[SLOTS];
        t_sched_result     expected_results[$];
        int n_errors;
        int n_commands;
        int n_results;
        int n_fires;
        int n_overwrite;
        int n_badslot;
        int max_tick_results;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                period_tbl[i]    = '0;
                countdown_tbl[i] = '0;
                ready_tbl[i]     = 1'b0;
            end
        endfunction

        // Append one expected result
        function void push_result(logic [KIND_W-1:0] kind, logic [STAT_W-1:0] status,
                                  int slot_idx, logic last);
            t_sched_result r;
            r.kind      = kind;
            r.status    = status;
            r.task_slot = slot_idx[TASK_W-1:0];
            r.last      = last;
            expected_results.push_back(r);
        endfunction

        // Advance the slot table by one accepted command
        function void note_input(t_sched_cmd c);
            logic [STAT_W-1:0] status;
            int                fired;
            int                idx;
            status = STAT_OK;
            fired  = 0;
            idx    = int'(c.slot);
            n_commands++;
            if (c.func == FUNC_TICK) begin
                // Visit occupied ready slots in ascending order
                for (int i = 0; i < SLOTS; i++) begin
                    if (period_tbl[i] != '0 && ready_tbl[i]) begin
                        if (countdown_tbl[i] != '0)
                            countdown_tbl[i] = countdown_tbl[i] - 1'b1;
                        if (countdown_tbl[i] == '0) begin
                            push_result(KIND_FIRE, STAT_OK, i, 1'b0);
                            countdown_tbl[i] = period_tbl[i];
                            fired++;
                        end
                    end
                end
                push_result(KIND_DONE, STAT_OK, 0, 1'b1);
                if (fired + 1 > max_tick_results)
                    max_tick_results = fired + 1;
            end else begin
                if (c.func <= FUNC_SUSPEND) begin
                    if (idx >= SLOTS) begin
                        status = STAT_BADSLOT;
                    end else if (c.func == FUNC_CREATE) begin
                        if (period_tbl[idx] == '0) begin
                            period_tbl[idx]    = c.period;
                            countdown_tbl[idx] = c.first_delay;
                            ready_tbl[idx]     = c.initial_ready;
                        end else begin
                            status = STAT_OVERWRITE;
                        end
                    end else if (c.func == FUNC_DELETE) begin
                        period_tbl[idx] = '0;
                    end else if (c.func == FUNC_RESUME) begin
                        ready_tbl[idx] = 1'b1;
                    end else begin
                        ready_tbl[idx] = 1'b0;
                    end
                end
                if (status == STAT_OVERWRITE)
                    n_overwrite++;
                if (status == STAT_BADSLOT)
                    n_badslot++;
                push_result(KIND_STATUS, status, 0, 1'b1);
            end
        endfunction

        // Print one mismatch line and count it
        task report_mismatch(string msg);
            n_errors++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        // Compare one accepted result against the oldest expectation
        task check_result(t_sched_result got);
            t_sched_result want;
            n_results++;
            if (got.kind == KIND_FIRE)
                n_fires++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf(
                    "unexpected result kind=%0d status=%0d slot=%0d last=%0d",
                    got.kind, got.status, got.task_slot, got.last));
            end else begin
                want = expected_results.pop_front();
                if (got.kind !== want.kind || got.status !== want.status ||
                    got.task_slot !== want.task_slot || got.last !== want.last)
                    report_mismatch($sformatf(
                        {"result %0d got kind=%0d status=%0d slot=%0d last=%0d, ",
                         "want %0d/%0d/%0d/%0d"},
                        n_results, got.kind, got.status, got.task_slot, got.last,
                        want.kind, want.status, want.task_slot, want.last));
            end
        endtask
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [FUNC_W-1:0]      s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;

    sched_scoreboard sb;
    t_sched_result   mon_result;
    int              cycle_count   = 0;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;

    periodic_task_tick_scheduler_core #(
        .NUM_SLOTS(SLOTS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free-running clock
    always #CLK_HALF i_clk = ~i_clk;

    // Bound the run length
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, sb.expected_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Stall the result port at random
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            mon_result.kind      = m_axis_tuser;
            mon_result.status    = m_axis_tdata[1:0];
            mon_result.task_slot = m_axis_tdata[4:2];
            mon_result.last      = m_axis_tlast;
            sb.check_result(mon_result);
        end
    end

    function automatic t_sched_cmd make_cmd(logic [FUNC_W-1:0] func, logic [SLOT_W-1:0] slot,
                                            logic [WORD_W-1:0] period,
                                            logic [WORD_W-1:0] first_delay, logic rdy);
        t_sched_cmd c;
        c.func          = func;
        c.slot          = slot;
        c.period        = period;
        c.first_delay   = first_delay;
        c.initial_ready = rdy;
        return c;
    endfunction

    // Draw a command biased toward small periods and valid slots so slots fire often
    function automatic t_sched_cmd random_cmd();
        t_sched_cmd c;
        int         pick;
        int         shape;
        pick            = $urandom_range(99);
        c.slot          = ($urandom_range(9) == 0) ? 8'($urandom_range(255, SLOTS))
                                                   : 8'($urandom_range(SLOTS - 1));
        c.period        = $urandom();
        c.first_delay   = $urandom();
        c.initial_ready = 1'($urandom_range(1));
        if (pick < 45) begin
            c.func = FUNC_TICK;
        end else if (pick < 72) begin
            c.func = FUNC_CREATE;
            shape = $urandom_range(9);
            if (shape < 7)
                c.period = $urandom_range(5, 1);
            else if (shape == 7)
                c.period = '0;
            shape = $urandom_range(9);
            if (shape < 7)
                c.first_delay = $urandom_range(5);
            c.initial_ready = ($urandom_range(99) < 85);
        end else if (pick < 82) begin
            c.func = FUNC_DELETE;
        end else if (pick < 89) begin
            c.func = FUNC_RESUME;
        end else if (pick < 95) begin
            c.func = FUNC_SUSPEND;
        end else begin
            c.func = 3'($urandom_range(FUNC_SPARE_LAST, FUNC_SPARE_FIRST));
        end
        return c;
    endfunction

    // Present one command and hold it until the transaction completes
    task automatic send_item(t_sched_cmd c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, c.initial_ready, c.first_delay, c.period, c.slot};
        s_axis_tuser  <= c.func;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        sb.note_input(c);
    endtask

    task automatic send_cmd(logic [FUNC_W-1:0] func, logic [SLOT_W-1:0] slot,
                            logic [WORD_W-1:0] period, logic [WORD_W-1:0] first_delay,
                            logic rdy);
        send_item(make_cmd(func, slot, period, first_delay, rdy));
    endtask

    // Hold the input idle until every expected result has arrived
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_idle_phase(int phase);
        case (phase)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 71;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 71;
            end
            default: begin
                send_idle_pct  = 30;
                recv_stall_pct = 30;
            end
        endcase
    endtask

    // Fill every slot with period one so each tick fires all of them
    task automatic fill_table_and_tick();
        for (int s = 0; s < SLOTS; s++)
            send_cmd(FUNC_DELETE, 8'(s), $urandom(), $urandom(), 1'($urandom_range(1)));
        for (int s = 0; s < SLOTS; s++)
            send_cmd(FUNC_CREATE, 8'(s), 32'd1, 32'd0, 1'b1);
        repeat (3)
            send_cmd(FUNC_TICK, 8'($urandom()), $urandom(), $urandom(), 1'b0);
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty tick, overwrite, bad slots, zero period and zero countdown
        set_idle_phase(0);
        send_cmd(FUNC_TICK,    8'd0,   32'd0,          32'd0,          1'b0);
        send_cmd(FUNC_CREATE,  8'd0,   32'd1,          32'd0,          1'b1);
        send_cmd(FUNC_CREATE,  8'd0,   32'd5,          32'd5,          1'b1);
        send_cmd(FUNC_CREATE,  8'd7,   32'hFFFF_FFFF,  32'd1,          1'b1);
        send_cmd(FUNC_CREATE,  8'd8,   32'd2,          32'd2,          1'b1);
        send_cmd(FUNC_CREATE,  8'd255, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1);
        send_cmd(FUNC_CREATE,  8'd3,   32'd0,          32'd5,          1'b1);
        send_cmd(FUNC_CREATE,  8'd5,   32'd2,          32'd3,          1'b0);
        send_cmd(FUNC_CREATE,  8'd6,   32'd3,          32'hFFFF_FFFF,  1'b1);
        send_cmd(FUNC_TICK,    8'd0,   32'd0,          32'd0,          1'b0);
        send_cmd(FUNC_TICK,    8'd255, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1);
        send_cmd(FUNC_RESUME,  8'd5,   32'd0,          32'd0,          1'b0);
        send_cmd(FUNC_TICK,    8'd0,   32'd0,          32'd0,          1'b0);
        send_cmd(FUNC_SUSPEND, 8'd0,   32'd0,          32'd0,          1'b0);
        send_cmd(FUNC_TICK,    8'd0,   32'd0,          32'd0,          1'b0);
        send_cmd(FUNC_DELETE,  8'd7,   32'd0,          32'd0,          1'b0);
        send_cmd(FUNC_CREATE,  8'd7,   32'd1,          32'd2,          1'b1);
        send_cmd(FUNC_TICK,    8'd0,   32'd0,          32'd0,          1'b0);
        send_cmd(FUNC_DELETE,  8'd200, 32'd0,          32'd0,          1'b0);
        send_cmd(FUNC_RESUME,  8'd8,   32'd0,          32'd0,          1'b0);
        send_cmd(FUNC_SUSPEND, 8'd255, 32'd0,          32'd0,          1'b0);
        send_cmd(FUNC_SPARE_FIRST, 8'd1, $urandom(),   $urandom(),     1'b1);
        send_cmd(FUNC_SPARE_MID,   8'd2, $urandom(),   $urandom(),     1'b0);
        send_cmd(FUNC_SPARE_LAST, 8'd3, $urandom(),    $urandom(),     1'b1);
        send_cmd(FUNC_CREATE,  8'd3,   32'd4,          32'd0,          1'b1);

        // Random segments across all idle phases
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            set_idle_phase(seg % 4);
            for (int n = 0; n < SEGMENT_ITEMS; n++)
                send_item(random_cmd());
            if (seg == 1 || seg == 5)
                wait_drained();
            if (seg == 3)
                fill_table_and_tick();
        end

        // Drain, then let the block settle
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d commands and %0d results, %0d task firings, %0s %0d",
                 sb.n_commands, sb.n_results, sb.n_fires, "most results in one tick:",
                 sb.max_tick_results);
        $display("Saw %0d overwrite and %0d bad-slot statuses under idle and stall phases",
                 sb.n_overwrite, sb.n_badslot);
        if (sb.n_errors == 0 && sb.expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
